### rtl/hslc_pkg.sv
// Shared constants, types and a helper function for the hashed set LRU tag cache.
`default_nettype none
package hslc_pkg;
    localparam int SETS      = 64;
    localparam int WAYS      = 16;
    localparam int KEY_WIDTH = 64;
    localparam int SET_W     = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_W     = $clog2(WAYS);
    localparam int ADDR_W    = SET_W + WAY_W;
    localparam int CNT_W     = 32;
    localparam int HASH_W    = 32;
    localparam int CFG_W     = 7;
    localparam int NBYTES    = (KEY_WIDTH + 7) / 8;
    localparam int BYTE_W    = (NBYTES > 1) ? $clog2(NBYTES) : 1;
    localparam int DIV_W     = $clog2(HASH_W + 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HASH,
        ST_DIV,
        ST_SCAN,
        ST_READ,
        ST_CMP,
        ST_UPD,
        ST_CLEAR,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic              start;
        logic [HASH_W-1:0] dividend;
        logic [CFG_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [SET_W-1:0] remainder;
    } div_rsp_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
    endfunction
endpackage
`default_nettype wire

### rtl/hashed_set_lru_tag_cache.sv
// Top level of the hashed set LRU tag cache: control sequencer, counters and ports.
`default_nettype none
// Usage
//   The lookup channel (lookup_valid / lookup_stall) carries one 64-bit key per
//   transaction. The result channel (result_valid / result_stall) returns one
//   transaction per key: hit flag, set, way, eviction flag, victim key and the
//   three saturating counters after this lookup.
//   The configuration channel (cfg_valid / cfg_ready) writes sets_in_use; it is
//   ready at all times and must only be written while nothing is in flight.
//   A lookup hashes the key one byte a cycle, reduces the hash in the
//   restoring remainder unit (start, 32 steps, done), then makes two passes over
//   the 16 ways of the set in the way store, each read word checked after the
//   store's read register: one to compare tags, one to write the new recency
//   ranks. A decision state and a state that loads the result register follow,
//   and only then is the next key taken: one lookup is in work at a time.
//   Reset clears the counters and sets sets_in_use to 64, then a clearing pass
//   over all 1024 entries marks every entry empty with rank equal to its way;
//   the lookup channel stalls during that pass.
//   When the receiver stalls, the result is held in the output register; the
//   next lookup may proceed but waits in its last cycle until the register frees.
module hashed_set_lru_tag_cache (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         lookup_valid,
    output logic        lookup_stall,
    input  wire  [63:0] lookup_key,
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [6:0]  cfg_data,
    output logic        result_valid,
    input  wire         result_stall,
    output logic        hit,
    output logic [5:0]  set_index,
    output logic [3:0]  way_index,
    output logic        evicted,
    output logic [63:0] victim_key,
    output logic [31:0] hit_total,
    output logic [31:0] miss_total,
    output logic [31:0] evict_total
);
    import hslc_pkg::*;

    state_t state_reg, state_next;
    logic [CFG_W-1:0]     sets_reg;
    logic [KEY_WIDTH-1:0] key_reg, key_next;
    logic [HASH_W-1:0]    hash_reg, hash_next;
    logic [BYTE_W-1:0]    byte_reg, byte_next;
    logic [SET_W-1:0]     set_reg, set_next;
    logic [WAY_W:0]       way_reg, way_next;
    logic [WAY_W-1:0]     hway_reg, hway_next;
    logic [WAY_W-1:0]     oldr_reg, oldr_next;
    logic                 hit_reg, hit_next;
    logic                 vict_reg, vict_next;
    logic [KEY_WIDTH-1:0] vkey_reg, vkey_next;
    logic [WAY_W-1:0]     lway_reg, lway_next;
    logic                 lval_reg, lval_next;
    logic [ADDR_W-1:0]    clr_reg, clr_next;
    logic [CNT_W-1:0]     hc_reg, mc_reg, ec_reg;
    logic                 out_v_reg;
    logic                 res_hit_reg;
    logic [SET_W-1:0]     res_set_reg;
    logic [WAY_W-1:0]     res_way_reg;
    logic                 res_vict_reg;
    logic [KEY_WIDTH-1:0] res_vkey_reg;
    logic                 deliver;
    logic                 res_load;
    logic [CFG_W-1:0]     n_eff;
    logic [7:0]           cur_byte;
    div_req_t             dreq;
    div_rsp_t             drsp;

    logic [ADDR_W-1:0]    rd_addr, wr_addr;
    logic                 wr_en, wr_valid, rd_valid;
    logic [KEY_WIDTH-1:0] wr_tag, rd_tag;
    logic [WAY_W-1:0]     wr_rank, rd_rank, rd_way;

    hslc_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    hslc_store u_store (
        .clk(clk), .rd_addr(rd_addr), .wr_en(wr_en), .wr_addr(wr_addr),
        .wr_tag(wr_tag), .wr_valid(wr_valid), .wr_rank(wr_rank),
        .rd_tag(rd_tag), .rd_valid(rd_valid), .rd_rank(rd_rank)
    );

    assign cfg_ready    = 1'b1;
    assign lookup_stall = (state_reg != ST_IDLE);
    assign deliver      = out_v_reg && !result_stall;
    // The finished lookup moves into the output register once that is free.
    assign res_load     = (state_reg == ST_DONE) && (!out_v_reg || deliver);
    assign cur_byte     = key_reg[8*byte_reg +: 8];
    // Out-of-range set counts are folded: zero acts as one, above SETS as SETS.
    assign n_eff = (sets_reg == '0) ? CFG_W'(1) :
                   (sets_reg > CFG_W'(SETS)) ? CFG_W'(SETS) : sets_reg;
    // The way whose word was read in the previous cycle.
    assign rd_way = way_reg[WAY_W-1:0] - 1'b1;

    always_comb
    begin
        state_next = state_reg;
        key_next   = key_reg;
        hash_next  = hash_reg;
        byte_next  = byte_reg;
        set_next   = set_reg;
        way_next   = way_reg;
        hway_next  = hway_reg;
        oldr_next  = oldr_reg;
        hit_next   = hit_reg;
        vict_next  = vict_reg;
        vkey_next  = vkey_reg;
        lway_next  = lway_reg;
        lval_next  = lval_reg;
        clr_next   = clr_reg;
        dreq.start    = 1'b0;
        dreq.dividend = hash_reg;
        dreq.divisor  = n_eff;
        rd_addr  = {set_reg, way_reg[WAY_W-1:0]};
        wr_en    = 1'b0;
        wr_addr  = {set_reg, rd_way};
        wr_tag   = rd_tag;
        wr_valid = rd_valid;
        wr_rank  = rd_rank;
        case (state_reg)
            ST_CLEAR:
            begin
                // One entry a cycle: empty, tag zero, rank equal to its way.
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                wr_tag   = '0;
                wr_valid = 1'b0;
                wr_rank  = clr_reg[WAY_W-1:0];
                clr_next = clr_reg + 1'b1;
                if (clr_reg == '1)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (lookup_valid && !lookup_stall)
                begin
                    key_next   = (KEY_WIDTH >= 64) ? lookup_key :
                                 lookup_key & ((64'd1 << KEY_WIDTH) - 64'd1);
                    hash_next  = '0;
                    byte_next  = '0;
                    state_next = ST_HASH;
                end
            end
            ST_HASH:
            begin
                hash_next = (hash_reg << 5) + hash_reg + HASH_W'(cur_byte);
                byte_next = byte_reg + 1'b1;
                if (byte_reg == BYTE_W'(NBYTES - 1))
                    state_next = ST_DIV;
                if (byte_reg == BYTE_W'(NBYTES - 1))
                    byte_next = '0;
            end
            ST_DIV:
            begin
                // Start pulse in the first cycle: byte_reg marks it.
                if (byte_reg == '0)
                begin
                    dreq.start = 1'b1;
                    byte_next  = BYTE_W'(1);
                end
                if (drsp.done)
                begin
                    set_next   = drsp.remainder;
                    way_next   = '0;
                    hit_next   = 1'b0;
                    lval_next  = 1'b0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // Compare pass: issue reads for all ways, check each in the next cycle.
                way_next = way_reg + 1'b1;
                if (way_reg != '0)
                begin
                    if (!hit_reg && rd_valid && rd_tag == key_reg)
                    begin
                        hit_next  = 1'b1;
                        hway_next = rd_way;
                        oldr_next = rd_rank;
                    end
                    if (rd_rank == WAY_W'(WAYS - 1))
                    begin
                        lway_next = rd_way;
                        lval_next = rd_valid;
                        vkey_next = rd_tag;
                    end
                end
                if (way_reg == (WAY_W+1)'(WAYS))
                begin
                    way_next   = '0;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (!hit_reg)
                begin
                    hway_next = lway_reg;
                    oldr_next = WAY_W'(WAYS - 1);
                end
                vict_next  = !hit_reg && lval_reg;
                if (hit_reg || !lval_reg)
                    vkey_next = '0;
                way_next   = '0;
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                // Rank pass: read each way and write back its updated rank, and the new tag on a miss.
                way_next = way_reg + 1'b1;
                if (way_reg != '0)
                begin
                    wr_en = 1'b1;
                    if (rd_way == hway_reg)
                    begin
                        wr_rank = '0;
                        if (!hit_reg)
                        begin
                            wr_tag   = key_reg;
                            wr_valid = 1'b1;
                        end
                    end
                    else if (rd_rank < oldr_reg)
                        wr_rank = rd_rank + 1'b1;
                end
                if (way_reg == (WAY_W+1)'(WAYS))
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (res_load)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            sets_reg  <= CFG_W'(64);
            hc_reg    <= '0;
            mc_reg    <= '0;
            ec_reg    <= '0;
            out_v_reg <= 1'b0;
            byte_reg  <= '0;
            way_reg   <= '0;
            hit_reg   <= 1'b0;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            byte_reg  <= byte_next;
            way_reg   <= way_next;
            hit_reg   <= hit_next;
            clr_reg   <= clr_next;
            if (cfg_valid && cfg_ready)
                sets_reg <= cfg_data;
            if (res_load)
            begin
                out_v_reg <= 1'b1;
                if (hit_reg)
                    hc_reg <= sat_inc(hc_reg);
                else
                    mc_reg <= sat_inc(mc_reg);
                if (vict_reg)
                    ec_reg <= sat_inc(ec_reg);
            end
            else if (deliver)
                out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        hash_reg <= hash_next;
        set_reg  <= set_next;
        hway_reg <= hway_next;
        oldr_reg <= oldr_next;
        vict_reg <= vict_next;
        vkey_reg <= vkey_next;
        lway_reg <= lway_next;
        lval_reg <= lval_next;
        if (res_load)
        begin
            res_hit_reg  <= hit_reg;
            res_set_reg  <= set_reg;
            res_way_reg  <= hway_reg;
            res_vict_reg <= vict_reg;
            res_vkey_reg <= vkey_reg;
        end
    end

    assign result_valid = out_v_reg;
    assign hit          = res_hit_reg;
    assign set_index    = 6'(res_set_reg);
    assign way_index    = 4'(res_way_reg);
    assign evicted      = res_vict_reg;
    assign victim_key   = 64'(res_vkey_reg);
    assign hit_total    = hc_reg;
    assign miss_total   = mc_reg;
    assign evict_total  = ec_reg;

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> lookup_stall)
        else $error("key accepted while a lookup is in work");
    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(hit && evicted))
        else $error("eviction reported on a hit");
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> (result_valid && $stable(hit_total)))
        else $error("stalled result changed");
    a_set_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ({1'b0, set_index} < n_eff)
        || ({1'b0, set_index} == '0))
        else $error("set index beyond set count");
endmodule
`default_nettype wire

### rtl/hslc_divider.sv
// Restoring remainder unit: reduces the 32-bit hash modulo the set count, one bit a cycle.
`default_nettype none
module hslc_divider (
    input  wire                   clk,
    input  wire                   rst_n,
    input  hslc_pkg::div_req_t    req,
    output hslc_pkg::div_rsp_t    rsp
);
    import hslc_pkg::*;

    logic [HASH_W-1:0] quo_reg, quo_next;
    logic [CFG_W:0]    rem_reg, rem_next;
    logic [CFG_W-1:0]  den_reg, den_next;
    logic [DIV_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CFG_W:0]    trial;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[CFG_W-1:0], quo_reg[HASH_W-1]};
        if (req.start)
        begin
            quo_next  = req.dividend;
            rem_next  = '0;
            den_next  = req.divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[HASH_W-2:0], 1'b0};
            if (trial >= {1'b0, den_reg})
                rem_next = trial - {1'b0, den_reg};
            else
                rem_next = trial;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_W'(HASH_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.remainder = rem_reg[SET_W-1:0];
endmodule
`default_nettype wire

### rtl/hslc_store.sv
// Way store: a tag memory and a valid-and-recency memory with one read and one write port each.
`default_nettype none
module hslc_store (
    input  wire                          clk,
    input  wire  [hslc_pkg::ADDR_W-1:0]  rd_addr,
    input  wire                          wr_en,
    input  wire  [hslc_pkg::ADDR_W-1:0]  wr_addr,
    input  wire  [hslc_pkg::KEY_WIDTH-1:0] wr_tag,
    input  wire                          wr_valid,
    input  wire  [hslc_pkg::WAY_W-1:0]   wr_rank,
    output logic [hslc_pkg::KEY_WIDTH-1:0] rd_tag,
    output logic                         rd_valid,
    output logic [hslc_pkg::WAY_W-1:0]   rd_rank
);
    import hslc_pkg::*;

    // One word per entry: valid and rank. The top level clears every entry
    // once after reset, so the content is always defined when it is read.
    localparam int META_W = WAY_W + 1;
    logic [KEY_WIDTH-1:0] tag_mem  [SETS*WAYS];
    logic [META_W-1:0]    meta_mem [SETS*WAYS];
    logic [META_W-1:0]    meta_q;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            tag_mem[wr_addr]  <= wr_tag;
            meta_mem[wr_addr] <= {wr_valid, wr_rank};
        end
        rd_tag <= tag_mem[rd_addr];
        meta_q <= meta_mem[rd_addr];
    end

    assign rd_valid = meta_q[WAY_W];
    assign rd_rank  = meta_q[WAY_W-1:0];
endmodule
`default_nettype wire

### test/tb_hashed_set_lru_tag_cache.sv
// Self-checking testbench for the hashed set LRU tag cache.
`default_nettype none
module tb_hashed_set_lru_tag_cache;
    import hslc_pkg::*;

    // A lookup transaction's expected outcome.
    typedef struct packed {
        logic        hit;
        logic [5:0]  set_index;
        logic [3:0]  way_index;
        logic        evicted;
        logic [63:0] victim_key;
        logic [31:0] hit_total;
        logic [31:0] miss_total;
        logic [31:0] evict_total;
    } lookup_outcome_t;

    logic        clk;
    logic        rst_n;
    logic        lookup_valid;
    logic        lookup_stall;
    logic [63:0] lookup_key;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [6:0]  cfg_data;
    logic        result_valid;
    logic        result_stall;
    logic        hit;
    logic [5:0]  set_index;
    logic [3:0]  way_index;
    logic        evicted;
    logic [63:0] victim_key;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
    logic [31:0] evict_total;

    hashed_set_lru_tag_cache uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .lookup_valid (lookup_valid),
        .lookup_stall (lookup_stall),
        .lookup_key   (lookup_key),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .hit          (hit),
        .set_index    (set_index),
        .way_index    (way_index),
        .evicted      (evicted),
        .victim_key   (victim_key),
        .hit_total    (hit_total),
        .miss_total   (miss_total),
        .evict_total  (evict_total)
    );

    // Shadow copy of the cache contents. Tags are only ever read where the
    // matching valid bit is set, so their initial value does not matter.
    logic [63:0]      shadow_tag   [SETS*WAYS];
    logic             shadow_valid [SETS*WAYS];
    logic [WAY_W-1:0] shadow_rank  [SETS*WAYS];
    logic [31:0]      hits_so_far;
    logic [31:0]      misses_so_far;
    logic [31:0]      evictions_so_far;
    logic [6:0]       shadow_sets_in_use;

    lookup_outcome_t  pending_outcomes[$];
    int               error_count;
    logic             traffic_done;

    // Keys already sent, reused so that hits and evictions happen often.
    logic [63:0]      recent_keys[$];

    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic logic [31:0] bernstein_hash(input logic [63:0] key);
        logic [31:0] h;
        h = 32'd0;
        for (int i = 0; i < 8; i++)
            h = h * 32'd33 + {24'd0, key[8*i +: 8]};
        return h;
    endfunction

    function automatic logic [31:0] saturating_inc(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    // Moves one way to most recent, ageing every way that was more recent.
    task automatic promote_way(input int base, input int way);
        logic [WAY_W-1:0] r;
        r = shadow_rank[base + way];
        for (int w = 0; w < WAYS; w++)
            if (shadow_rank[base + w] < r)
                shadow_rank[base + w] = shadow_rank[base + w] + 1'b1;
        shadow_rank[base + way] = '0;
    endtask

    // Works out the outcome of one accepted lookup and updates the shadow state.
    task automatic predict_lookup(input logic [63:0] key);
        lookup_outcome_t o;
        int              n;
        int              set_no;
        int              base;
        int              way;
        logic            found;
        n = shadow_sets_in_use;
        if (n == 0)
            n = 1;
        if (n > SETS)
            n = SETS;
        set_no = int'(bernstein_hash(key) % n);
        base   = set_no * WAYS;
        found  = 1'b0;
        way    = 0;
        o      = '0;
        for (int w = 0; w < WAYS; w++)
            if (!found && shadow_valid[base + w] && shadow_tag[base + w] == key)
            begin
                found = 1'b1;
                way   = w;
            end
        if (found)
        begin
            promote_way(base, way);
            hits_so_far = saturating_inc(hits_so_far);
        end
        else
        begin
            for (int w = 0; w < WAYS; w++)
                if (shadow_rank[base + w] == WAYS - 1)
                    way = w;
            if (shadow_valid[base + way])
            begin
                o.evicted        = 1'b1;
                o.victim_key     = shadow_tag[base + way];
                evictions_so_far = saturating_inc(evictions_so_far);
            end
            shadow_tag[base + way]   = key;
            shadow_valid[base + way] = 1'b1;
            promote_way(base, way);
            misses_so_far = saturating_inc(misses_so_far);
        end
        o.hit         = found;
        o.set_index   = set_no[5:0];
        o.way_index   = way[3:0];
        o.hit_total   = hits_so_far;
        o.miss_total  = misses_so_far;
        o.evict_total = evictions_so_far;
        pending_outcomes.push_back(o);
    endtask

    // Mostly short gaps, now and then a long one.
    function automatic int random_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        if (pick < 92)
            return $urandom_range(1, 4);
        return $urandom_range(20, 120);
    endfunction

    // Sends one key, holding it steady until the block accepts it. Valid stays
    // high after acceptance when the next key follows at once.
    task automatic send_lookup(input logic [63:0] key, input logic with_gaps);
        int gap;
        gap = with_gaps ? random_gap() : 0;
        if (gap != 0)
        begin
            lookup_valid <= 1'b0;
            lookup_key   <= {$urandom, $urandom};
            repeat (gap) @(posedge clk);
        end
        lookup_valid <= 1'b1;
        lookup_key   <= key;
        @(posedge clk);
        while (lookup_stall)
            @(posedge clk);
        predict_lookup(key);
        recent_keys.push_back(key);
        if (recent_keys.size() > 48)
            void'(recent_keys.pop_front());
    endtask

    // Drops valid, waits for every outstanding result, then for the block to settle.
    task automatic wait_until_idle();
        lookup_valid <= 1'b0;
        lookup_key   <= {$urandom, $urandom};
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_sets_in_use(input logic [6:0] value);
        wait_until_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        shadow_sets_in_use = value;
    endtask

    // Results: the receiver stalls at random, and every accepted
    // transaction is checked against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (pending_outcomes.size() == 0)
                begin
                    $display("%0t: unexpected result transaction", $time);
                    error_count++;
                end
                else
                begin
                    lookup_outcome_t e;
                    e = pending_outcomes.pop_front();
                    if (hit !== e.hit)
                    begin
                        $display("%0t: hit expected %0h actual %0h", $time, e.hit, hit);
                        error_count++;
                    end
                    if (set_index !== e.set_index)
                    begin
                        $display("%0t: set_index expected %0h actual %0h",
                                 $time, e.set_index, set_index);
                        error_count++;
                    end
                    if (way_index !== e.way_index)
                    begin
                        $display("%0t: way_index expected %0h actual %0h",
                                 $time, e.way_index, way_index);
                        error_count++;
                    end
                    if (evicted !== e.evicted)
                    begin
                        $display("%0t: evicted expected %0h actual %0h",
                                 $time, e.evicted, evicted);
                        error_count++;
                    end
                    if (victim_key !== e.victim_key)
                    begin
                        $display("%0t: victim_key expected %0h actual %0h",
                                 $time, e.victim_key, victim_key);
                        error_count++;
                    end
                    if (hit_total !== e.hit_total)
                    begin
                        $display("%0t: hit_total expected %0h actual %0h",
                                 $time, e.hit_total, hit_total);
                        error_count++;
                    end
                    if (miss_total !== e.miss_total)
                    begin
                        $display("%0t: miss_total expected %0h actual %0h",
                                 $time, e.miss_total, miss_total);
                        error_count++;
                    end
                    if (evict_total !== e.evict_total)
                    begin
                        $display("%0t: evict_total expected %0h actual %0h",
                                 $time, e.evict_total, evict_total);
                        error_count++;
                    end
                end
            end
        end
    end

    // Stall pattern for the result side: runs of stall and of free flow, with
    // long stretches of either once in a while.
    initial
    begin
        int span;
        result_stall = 1'b0;
        @(posedge rst_n);
        while (!traffic_done)
        begin
            span = random_gap();
            result_stall <= (span != 0);
            repeat (span + 1) @(posedge clk);
            result_stall <= 1'b0;
            repeat (random_gap() + 1) @(posedge clk);
        end
        result_stall <= 1'b0;
    end

    // Directed: field extremes, single-bit keys and keys that are zero.
    task automatic test_key_extremes();
        send_lookup(64'd0, 1'b0);
        send_lookup(64'd0, 1'b0);
        send_lookup(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        send_lookup(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        send_lookup(64'h8000_0000_0000_0000, 1'b0);
        send_lookup(64'h0000_0000_0000_0001, 1'b0);
        send_lookup(64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
        send_lookup(64'h5555_5555_5555_5555, 1'b0);
    endtask

    // Directed: a single set in use, so seventeen distinct keys fill all
    // ways and then evict the oldest; the first key is then a miss.
    task automatic test_single_set_eviction();
        write_sets_in_use(7'd1);
        for (int i = 0; i < WAYS + 1; i++)
            send_lookup(64'h1000 + i, 1'b0);
        send_lookup(64'h1000, 1'b0);
    endtask

    // Directed: a set count of zero acts as one, above the set count acts as
    // the full count, and a change of count flushes nothing.
    task automatic test_set_count_limits();
        write_sets_in_use(7'd0);
        send_lookup(64'h1005, 1'b0);
        write_sets_in_use(7'd127);
        send_lookup(64'h1005, 1'b0);
        send_lookup(64'hDEAD_BEEF_0000_0001, 1'b0);
        write_sets_in_use(7'd65);
        send_lookup(64'hDEAD_BEEF_0000_0001, 1'b0);
        write_sets_in_use(7'd64);
    endtask

    // Random keys, most of them drawn again from recently used ones so that
    // hits and LRU reordering are frequent, the rest fresh.
    task automatic test_random_lookups(input int count, input int key_pool);
        logic [63:0] key;
        for (int i = 0; i < count; i++)
        begin
            if (recent_keys.size() != 0 && $urandom_range(0, 99) < 55)
                key = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
            else if ($urandom_range(0, 3) == 0)
                key = {$urandom, $urandom};
            else
                key = 64'h4000 + $urandom_range(0, key_pool);
            send_lookup(key, 1'b1);
        end
    endtask

    // Random phases, each under its own set count.
    task automatic test_random_phases();
        logic [6:0] counts[6];
        counts = '{7'd64, 7'd1, 7'd3, 7'd17, 7'd2, 7'd64};
        foreach (counts[p])
        begin
            write_sets_in_use(counts[p]);
            test_random_lookups(230, (counts[p] == 7'd1) ? 40 : 600);
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        lookup_valid = 1'b0;
        lookup_key   = '0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        error_count  = 0;
        traffic_done = 1'b0;
        for (int i = 0; i < SETS*WAYS; i++)
        begin
            shadow_tag[i]   = '0;
            shadow_valid[i] = 1'b0;
            shadow_rank[i]  = WAY_W'(i % WAYS);
        end
        hits_so_far        = '0;
        misses_so_far      = '0;
        evictions_so_far   = '0;
        shadow_sets_in_use = 7'd64;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_key_extremes();
        test_single_set_eviction();
        test_set_count_limits();
        test_random_phases();

        wait_until_idle();
        repeat (100) @(posedge clk);
        traffic_done = 1'b1;
        if (error_count == 0 && pending_outcomes.size() == 0)
            $display("tb_hashed_set_lru_tag_cache passed");
        else
            $display("tb_hashed_set_lru_tag_cache failed");
        $finish;
    end

    // Timeout for roughly 1410 lookups plus gaps and result stalls; reaching it
    // reports failure.
    initial
    begin
        #(12 * 4000000);
        $display("tb_hashed_set_lru_tag_cache failed");
        $finish;
    end
endmodule
`default_nettype wire

### filelist.f
rtl/hslc_pkg.sv
rtl/hslc_divider.sv
rtl/hslc_store.sv
rtl/hashed_set_lru_tag_cache.sv
test/tb_hashed_set_lru_tag_cache.sv
